[rtl/core/ss_pkg.sv]
// ----------------------------------------------------------------------------
// ss_pkg
// Shared types, constants and codes of the sorted set store.
// ----------------------------------------------------------------------------
package ss_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned ECNT_W = 11;
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_UNDER    = 3'd3,
    ST_OVER     = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT,
    S_INS,
    S_GET_RD,
    S_GET_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [KEY_W-1:0]  wdata;
    logic [ADDR_W-1:0]        raddr;
  } mem_req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [KEY_W-1:0]  value;
    logic [ECNT_W-1:0]        count;
  } result_t;

endpackage

[rtl/core/ss_if.sv]
// ----------------------------------------------------------------------------
// ss_cmd_if / ss_res_if
// Valid/ready channels for commands and results of the sorted set store.
// ----------------------------------------------------------------------------
interface ss_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [ss_pkg::CMD_W-1:0]        command;
  logic signed [ss_pkg::KEY_W-1:0] key;
  logic [ss_pkg::POS_W-1:0]        position;

  modport source (output valid, command, key, position, input ready);
  modport sink   (input valid, command, key, position, output ready);
endinterface

interface ss_res_if;
  logic                             valid;
  logic                             ready;
  logic [ss_pkg::STAT_W-1:0]        status;
  logic signed [ss_pkg::KEY_W-1:0]  read_value;
  logic [ss_pkg::ECNT_W-1:0]        entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

[rtl/core/sorted_set_store.sv]
// ----------------------------------------------------------------------------
// sorted_set_store
// Set of distinct signed keys held in ascending order in one RAM, with count.
// ----------------------------------------------------------------------------
//  channel | dir | fields                             | role
//  cmd_i   | in  | command, key, position             | add / get / delete
//  res_o   | out | status, read_value, entry_count    | one result per add, get or delete
//
//  Get reads one RAM word; add and delete run a binary search for the slot,
//  then shift the entries past the slot up (add) or down (delete).
//  The single RAM port pair sets the rate: one read and one write a cycle.
//  One command is worked at a time; the next transfer is taken once the
//  result sits in the output register. The unused command yields no result.
//  Reset clears the count; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_set_store (
  input  logic     clk_i,
  input  logic     rst_ni,
  ss_cmd_if.sink   cmd_i,
  ss_res_if.source res_o
);

  ss_pkg::mem_req_t                mem_req;
  logic signed [ss_pkg::KEY_W-1:0] mem_rdata;
  logic                            res_valid;
  logic                            res_free;
  ss_pkg::result_t                 res;
  logic                            out_valid_q;
  ss_pkg::result_t                 out_q;

  ss_ram #(
    .DEPTH (ss_pkg::CAPACITY),
    .WIDTH (ss_pkg::KEY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  ss_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .cmd_i       (cmd_i.command),
    .key_i       (cmd_i.key),
    .pos_i       (cmd_i.position),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign res_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_q.status;
  assign res_o.read_value  = out_q.value;
  assign res_o.entry_count = out_q.count;

endmodule

[rtl/core/ss_ram.sv]
// ----------------------------------------------------------------------------
// ss_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ss_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ss_seq.sv]
// ----------------------------------------------------------------------------
// ss_seq
// Command sequencer: binary search, shift up or down, insert and read.
// ----------------------------------------------------------------------------
module ss_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ss_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [ss_pkg::KEY_W-1:0] key_i,
  input  logic [ss_pkg::POS_W-1:0]        pos_i,
  output ss_pkg::mem_req_t                mem_req_o,
  input  logic signed [ss_pkg::KEY_W-1:0] mem_rdata_i,
  input  logic                            res_free_i,
  output logic                            res_valid_o,
  output ss_pkg::result_t                 res_o
);

  localparam int unsigned AW = ss_pkg::ADDR_W;
  localparam int unsigned CW = ss_pkg::CNT_W;

  ss_pkg::state_e                  state_q, state_d;
  ss_pkg::cmd_e                    cmd_q, cmd_d;
  logic signed [ss_pkg::KEY_W-1:0] key_q, key_d;
  logic [ss_pkg::POS_W-1:0]        pos_q, pos_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]                   left_q, left_d;
  logic                            eq_q, eq_d;
  logic [AW-1:0]                   ptr_q, ptr_d;
  logic                            pend_q, pend_d;
  logic [AW-1:0]                   pend_addr_q, pend_addr_d;
  ss_pkg::status_e                 status_q, status_d;
  logic signed [ss_pkg::KEY_W-1:0] value_q, value_d;
  logic [CW:0]                     mid_sum;
  logic [CW-1:0]                   mid_w;
  logic                            is_add;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w   = mid_sum[CW:1];
  assign is_add  = (cmd_q == ss_pkg::CMD_ADD);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pos_d       = pos_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    left_d      = left_q;
    eq_d        = eq_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    status_d    = status_q;
    value_d     = value_q;
    case (state_q)
      ss_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = ss_pkg::cmd_e'(cmd_i);
          key_d    = key_i;
          pos_d    = pos_i;
          status_d = ss_pkg::ST_OK;
          value_d  = '0;
          lo_d     = '0;
          hi_d     = count_q;
          eq_d     = 1'b0;
          case (ss_pkg::cmd_e'(cmd_i))
            ss_pkg::CMD_ADD, ss_pkg::CMD_DEL: begin
              state_d = ss_pkg::S_SRCH_RD;
            end
            ss_pkg::CMD_GET: begin
              if (pos_i == '0) begin
                status_d = ss_pkg::ST_UNDER;
                state_d  = ss_pkg::S_DONE;
              end else if (ss_pkg::CMP_W'(pos_i) > ss_pkg::CMP_W'(count_q)) begin
                status_d = ss_pkg::ST_OVER;
                state_d  = ss_pkg::S_DONE;
              end else begin
                state_d = ss_pkg::S_GET_RD;
              end
            end
            default: begin
              state_d = ss_pkg::S_IDLE;
            end
          endcase
        end
      end
      ss_pkg::S_SRCH_RD: begin
        if (lo_q == hi_q) begin
          if (is_add) begin
            if (eq_q) begin
              status_d = ss_pkg::ST_EXISTS;
              state_d  = ss_pkg::S_DONE;
            end else if (count_q == CW'(ss_pkg::CAPACITY)) begin
              status_d = ss_pkg::ST_FULL;
              state_d  = ss_pkg::S_DONE;
            end else begin
              left_d  = count_q - lo_q;
              ptr_d   = AW'(count_q - 1'b1);
              state_d = ss_pkg::S_SHIFT;
            end
          end else begin
            if (!eq_q) begin
              status_d = ss_pkg::ST_NOTFOUND;
              state_d  = ss_pkg::S_DONE;
            end else begin
              left_d  = count_q - lo_q - 1'b1;
              ptr_d   = AW'(lo_q + 1'b1);
              state_d = ss_pkg::S_SHIFT;
            end
          end
        end else begin
          mid_d   = mid_w;
          state_d = ss_pkg::S_SRCH_CMP;
        end
      end
      ss_pkg::S_SRCH_CMP: begin
        if (mem_rdata_i < key_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
          eq_d = (mem_rdata_i == key_q);
        end
        state_d = ss_pkg::S_SRCH_RD;
      end
      ss_pkg::S_SHIFT: begin
        if (left_q != '0) begin
          left_d = left_q - 1'b1;
          pend_d = 1'b1;
          if (is_add) begin
            ptr_d       = ptr_q - 1'b1;
            pend_addr_d = ptr_q + 1'b1;
          end else begin
            ptr_d       = ptr_q + 1'b1;
            pend_addr_d = ptr_q - 1'b1;
          end
        end else if (!pend_q) begin
          if (is_add) begin
            state_d = ss_pkg::S_INS;
          end else begin
            count_d = count_q - 1'b1;
            state_d = ss_pkg::S_DONE;
          end
        end
      end
      ss_pkg::S_INS: begin
        count_d = count_q + 1'b1;
        state_d = ss_pkg::S_DONE;
      end
      ss_pkg::S_GET_RD: begin
        state_d = ss_pkg::S_GET_WAIT;
      end
      ss_pkg::S_GET_WAIT: begin
        value_d = mem_rdata_i;
        state_d = ss_pkg::S_DONE;
      end
      ss_pkg::S_DONE: begin
        if (res_free_i) begin
          state_d = ss_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ss_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ss_pkg::S_IDLE);
    res_valid_o     = (state_q == ss_pkg::S_DONE) && res_free_i;
    res_o.status    = status_q;
    res_o.value     = value_q;
    res_o.count     = ss_pkg::ECNT_W'(count_q);
    mem_req_o.we    = pend_q;
    mem_req_o.waddr = pend_addr_q;
    mem_req_o.wdata = mem_rdata_i;
    mem_req_o.raddr = '0;
    case (state_q)
      ss_pkg::S_SRCH_RD: begin
        mem_req_o.raddr = AW'(mid_w);
      end
      ss_pkg::S_SHIFT: begin
        mem_req_o.raddr = ptr_q;
      end
      ss_pkg::S_INS: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = AW'(lo_q);
        mem_req_o.wdata = key_q;
      end
      ss_pkg::S_GET_RD: begin
        mem_req_o.raddr = AW'(pos_q - 1'b1);
      end
      default: begin
        mem_req_o.raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ss_pkg::S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    pos_q       <= pos_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    left_q      <= left_d;
    eq_q        <= eq_d;
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    status_q    <= status_d;
    value_q     <= value_d;
  end

endmodule

[rtl/core/ss_checker.sv]
// ----------------------------------------------------------------------------
// ss_checker
// Port-level checks of the sorted set store, bound to the top level.
// ----------------------------------------------------------------------------
module ss_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             res_valid_i,
  input logic                             res_ready_i,
  input logic [ss_pkg::STAT_W-1:0]        status_i,
  input logic signed [ss_pkg::KEY_W-1:0]  read_value_i,
  input logic [ss_pkg::ECNT_W-1:0]        entry_count_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result transfer dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (status_i <= ss_pkg::ST_FULL))
    else $error("status code out of range");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i != ss_pkg::ST_OK) |-> (read_value_i == '0))
    else $error("read value nonzero on failed command");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (ss_pkg::CMP_W'(entry_count_i) <= ss_pkg::CMP_W'(ss_pkg::CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind sorted_set_store ss_checker u_ss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .status_i      (res_o.status),
  .read_value_i  (res_o.read_value),
  .entry_count_i (res_o.entry_count)
);
